// ----- design/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper with cycle IRQ.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam logic [2:0] MODE_WRITE  = 3'd0;
   localparam logic [2:0] MODE_READ   = 3'd1;
   localparam logic [2:0] MODE_TICK   = 3'd2;
   localparam logic [2:0] MODE_CPU_XL = 3'd3;
   localparam logic [2:0] MODE_PPU_XL = 3'd4;

   localparam logic [2:0] CHIP_ROM0 = 3'd0;
   localparam logic [2:0] CHIP_ROM1 = 3'd1;
   localparam logic [2:0] CHIP_WRAM = 3'd2;
   localparam logic [2:0] CHIP_CHR  = 3'd3;
   localparam logic [2:0] CHIP_NONE = 3'd4;

   localparam logic [15:0] ADDR_LATCH_LO = 16'hD600;
   localparam logic [15:0] ADDR_LATCH_HI = 16'hD700;
   localparam logic [15:0] ADDR_ACK      = 16'hD800;
   localparam logic [15:0] ADDR_RELOAD   = 16'hD900;
   localparam logic [15:0] ADDR_READ_C   = 16'hDC00;
   localparam logic [15:0] ADDR_READ_D   = 16'hDD00;

   localparam logic [7:0] PRG_ROM1_BASE = 8'h40;
   localparam logic [7:0] BANK_LAST     = 8'hFF;
   localparam logic [7:0] BANK_WRAM_HI  = 8'd2;

   typedef struct packed {
      logic [7:0]  cycles;
      logic [7:0]  wdata;
      logic [15:0] address;
      logic [2:0]  mode;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_hit;
      logic       irq_line;
   } status_type;

   typedef struct packed {
      logic       wram_bank;
      logic [7:0] prg_8000;
      logic [7:0] prg_a000;
      logic [7:0] prg_c000;
      logic       chr_bank;
   } banks_type;

   typedef struct packed {
      logic [2:0]  chip;
      logic [7:0]  bank;
      logic [12:0] offset;
   } xlate_type;

   typedef struct packed {
      logic [12:0] offset;
      logic [7:0]  bank;
      logic [2:0]  chip;
      logic        irq_line;
      logic        read_hit;
      logic [7:0]  read_data;
   } result_type;

endpackage

// ----- design/cbm_regs.sv -----
// ----------------------------------------------------------------------------
// cbm_regs
// Mapper register file and cycle IRQ counter; updates on each executed item.
// ----------------------------------------------------------------------------
module cbm_regs #(
   parameter int REG_COUNT = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                exec,
   input  cbm_pkg::item_type   item,
   output cbm_pkg::status_type status,
   output cbm_pkg::banks_type  banks
);

   localparam int IDX_W = $clog2(REG_COUNT);

   logic [7:0]       reg_file_ff [REG_COUNT];
   logic [15:0]      latch_ff, latch_in;
   logic [16:0]      counter_ff, counter_in;
   logic             enable_ff, enable_in;
   logic             reenable_ff, reenable_in;
   logic             pending_ff, pending_in;
   logic [IDX_W-1:0] idx;
   logic             wr_hit;
   logic [16:0]      counter_sum;
   logic [8:0]       read_sum;
   logic             read_hit;

   assign idx         = item.address[8 +: IDX_W];
   assign wr_hit      = (item.mode == cbm_pkg::MODE_WRITE) && item.address[15];
   assign counter_sum = counter_ff + {9'd0, item.cycles};
   assign read_sum    = {1'b0, reg_file_ff[idx]} + {1'b0, reg_file_ff[IDX_W'(11)]};
   assign read_hit    = (item.mode == cbm_pkg::MODE_READ) &&
                        ((item.address == cbm_pkg::ADDR_READ_C) ||
                         (item.address == cbm_pkg::ADDR_READ_D));

   always_comb begin
      latch_in    = latch_ff;
      counter_in  = counter_ff;
      enable_in   = enable_ff;
      reenable_in = reenable_ff;
      pending_in  = pending_ff;
      unique case (item.mode)
         cbm_pkg::MODE_WRITE: begin
            if (wr_hit) begin
               priority if (item.address == cbm_pkg::ADDR_LATCH_LO) begin
                  latch_in = {latch_ff[15:8], item.wdata};
               end else if (item.address == cbm_pkg::ADDR_LATCH_HI) begin
                  latch_in = {item.wdata, latch_ff[7:0]};
               end else if (item.address == cbm_pkg::ADDR_RELOAD) begin
                  counter_in  = {1'b0, latch_ff};
                  enable_in   = item.wdata[1];
                  reenable_in = item.wdata[0];
                  pending_in  = 1'b0;
               end else if (item.address == cbm_pkg::ADDR_ACK) begin
                  enable_in  = reenable_ff;
                  pending_in = 1'b0;
               end else begin
               end
            end
         end
         cbm_pkg::MODE_TICK: begin
            if (enable_ff) begin
               counter_in = counter_sum;
               if (counter_sum[16]) begin
                  pending_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_file_ff[i] <= 8'd0;
         end
         latch_ff    <= 16'd0;
         counter_ff  <= 17'd0;
         enable_ff   <= 1'b0;
         reenable_ff <= 1'b0;
         pending_ff  <= 1'b0;
      end else if (exec) begin
         if (wr_hit) begin
            reg_file_ff[idx] <= item.wdata;
         end
         latch_ff    <= latch_in;
         counter_ff  <= counter_in;
         enable_ff   <= enable_in;
         reenable_ff <= reenable_in;
         pending_ff  <= pending_in;
      end
   end

   assign status.read_hit  = read_hit;
   assign status.read_data = read_hit ? read_sum[7:0] : 8'd0;
   assign status.irq_line  = pending_in;

   assign banks.wram_bank = reg_file_ff[IDX_W'(0)][0];
   assign banks.prg_8000  = reg_file_ff[IDX_W'(2)];
   assign banks.prg_a000  = reg_file_ff[IDX_W'(3)];
   assign banks.prg_c000  = reg_file_ff[IDX_W'(4)];
   assign banks.chr_bank  = reg_file_ff[IDX_W'(5)][0];

endmodule

// ----- design/cbm_xlate.sv -----
// ----------------------------------------------------------------------------
// cbm_xlate
// CPU and PPU address windows to chip, bank and offset.
// ----------------------------------------------------------------------------
module cbm_xlate (
   input  cbm_pkg::item_type  item,
   input  cbm_pkg::banks_type banks,
   output cbm_pkg::xlate_type xlate
);

   logic [7:0]  prg_val;
   logic [15:0] addr;

   assign addr = item.address;

   always_comb begin
      priority if (addr[15:13] == 3'b110) begin
         prg_val = banks.prg_c000;
      end else if (addr[15:13] == 3'b101) begin
         prg_val = banks.prg_a000;
      end else begin
         prg_val = banks.prg_8000;
      end
   end

   always_comb begin
      xlate.chip   = cbm_pkg::CHIP_NONE;
      xlate.bank   = 8'd0;
      xlate.offset = 13'd0;
      unique case (item.mode)
         cbm_pkg::MODE_CPU_XL: begin
            priority if (addr[15:13] == 3'b111) begin
               xlate.chip   = cbm_pkg::CHIP_ROM1;
               xlate.bank   = cbm_pkg::BANK_LAST;
               xlate.offset = addr[12:0];
            end else if (addr[15]) begin
               if (prg_val >= cbm_pkg::PRG_ROM1_BASE) begin
                  xlate.chip = cbm_pkg::CHIP_ROM1;
                  xlate.bank = prg_val - cbm_pkg::PRG_ROM1_BASE;
               end else begin
                  xlate.chip = cbm_pkg::CHIP_ROM0;
                  xlate.bank = prg_val;
               end
               xlate.offset = addr[12:0];
            end else if (addr[15:12] == 4'h7) begin
               xlate.chip   = cbm_pkg::CHIP_WRAM;
               xlate.bank   = cbm_pkg::BANK_WRAM_HI;
               xlate.offset = {1'b0, addr[11:0]};
            end else if (addr[15:12] == 4'h6) begin
               xlate.chip   = cbm_pkg::CHIP_WRAM;
               xlate.bank   = {7'd0, banks.wram_bank};
               xlate.offset = {1'b0, addr[11:0]};
            end else begin
            end
         end
         cbm_pkg::MODE_PPU_XL: begin
            priority if (addr[15:12] == 4'h0) begin
               xlate.chip   = cbm_pkg::CHIP_CHR;
               xlate.bank   = {7'd0, banks.chr_bank};
               xlate.offset = {1'b0, addr[11:0]};
            end else if (addr[15:12] == 4'h1) begin
               xlate.chip   = cbm_pkg::CHIP_CHR;
               xlate.bank   = 8'd0;
               xlate.offset = {1'b0, addr[11:0]};
            end else begin
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- design/cartridge_bank_mapper_irq_unit.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_unit
// A request transfer is registered in the input register and then in the output
// register that drives rsp_tvalid; a stalled response can hold it in between.
// Throughput: one item per cycle while the response side keeps up.
// While a finished response waits, one more request is taken into the input
// register, then req_tready drops until the response is taken.
// Reset clears the register file, IRQ latch, counter, enables and pending.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_unit #(
   parameter int REG_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // address[15:0], wdata[23:16], cycles[31:24]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_data[7:0], read_hit[8], irq_line[9],
                                    // chip[12:10], bank[20:13], offset[33:21]
);

   cbm_pkg::item_type   in_ff;
   logic                in_valid_ff;
   cbm_pkg::result_type out_ff, out_in;
   logic                out_valid_ff;
   logic                exec;
   cbm_pkg::status_type status;
   cbm_pkg::banks_type  banks;
   cbm_pkg::xlate_type  xlate;

   assign exec       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff.mode    <= req_tuser;
         in_ff.address <= req_tdata[15:0];
         in_ff.wdata   <= req_tdata[23:16];
         in_ff.cycles  <= req_tdata[31:24];
      end
   end

   cbm_regs #(
      .REG_COUNT(REG_COUNT)
   ) u_regs (
      .clock (clock),
      .reset (reset),
      .exec  (exec),
      .item  (in_ff),
      .status(status),
      .banks (banks)
   );

   cbm_xlate u_xlate (
      .item (in_ff),
      .banks(banks),
      .xlate(xlate)
   );

   always_comb begin
      out_in.read_data = status.read_data;
      out_in.read_hit  = status.read_hit;
      out_in.irq_line  = status.irq_line;
      out_in.chip      = xlate.chip;
      out_in.bank      = xlate.bank;
      out_in.offset    = xlate.offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (exec) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff};

endmodule

// ----- design/cbm_checker.sv -----
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks for the mapper unit, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[7:0] == 8'd0)
      else $error("read data without read hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |->
         rsp_tdata[12:10] == cbm_pkg::CHIP_NONE && rsp_tdata[33:13] == 21'd0)
      else $error("read hit carries a translation");

endmodule

bind cartridge_bank_mapper_irq_unit cbm_checker u_cbm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
